### hw/rtl/bfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap frame allocator package
// Sizes, opcodes, status codes and controller/datapath link types.
// ----------------------------------------------------------------------------
package bfa_pkg;

	localparam int NUM_FRAMES  = 3840;
	localparam int WORD_BITS   = 32;
	localparam int MAP_WORDS   = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int ADDR_W      = 32;
	localparam int FRAME_SHIFT = 12;
	localparam int OPCODE_W    = 2;
	localparam int STATUS_W    = 3;
	localparam int FREE_W      = 12;
	localparam int BIT_W       = $clog2(WORD_BITS);
	localparam int WIDX_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int CNT_W       = $clog2(NUM_FRAMES + 1);
	localparam int GRP_SIZE    = 8;
	localparam int GRP_K_W     = $clog2(GRP_SIZE);
	localparam int NUM_GROUPS  = (MAP_WORDS + GRP_SIZE - 1) / GRP_SIZE;
	localparam int GIDX_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
	localparam int TAIL_BITS   = MAP_WORDS * WORD_BITS - NUM_FRAMES;

	localparam logic [ADDR_W-1:0]    POOL_BYTES   = ADDR_W'(NUM_FRAMES * (1 << FRAME_SHIFT));
	localparam logic [ADDR_W-1:0]    DEFAULT_BASE = 32'h0010_0000;
	localparam logic [WORD_BITS-1:0] TAIL_MASK    = ~({WORD_BITS{1'b1}} >> TAIL_BITS);
	localparam logic [CNT_W-1:0]     CNT_RESET    = CNT_W'(NUM_FRAMES);

	typedef enum logic [OPCODE_W-1:0] {
		OP_CLEAR = 2'd0,
		OP_ALLOC = 2'd1,
		OP_FREE  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK           = 3'd0,
		ST_FULL         = 3'd1,
		ST_OUT          = 3'd2,
		ST_MISALIGNED   = 3'd3,
		ST_ALREADY_FREE = 3'd4
	} status_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic pick;
		logic check;
		logic emit;
	} bfa_cmd_t;

	typedef struct packed {
		op_t  op;
		logic exec_last;
	} bfa_stat_t;

endpackage

### hw/rtl/bfa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap frame allocator channels
// Request and response valid/ready channels with their payloads.
// ----------------------------------------------------------------------------
interface bfa_req_if;
	logic                         valid;
	logic                         ready;
	logic [bfa_pkg::OPCODE_W-1:0] opcode;
	logic [bfa_pkg::ADDR_W-1:0]   frame_addr;

	modport source (output valid, output opcode, output frame_addr, input ready);
	modport sink (input valid, input opcode, input frame_addr, output ready);
endinterface

interface bfa_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [bfa_pkg::ADDR_W-1:0]   alloc_addr;
	logic [bfa_pkg::STATUS_W-1:0] status;
	logic [bfa_pkg::FREE_W-1:0]   free_frames;

	modport source (output valid, output alloc_addr, output status, output free_frames,
		input ready);
	modport sink (input valid, input alloc_addr, input status, input free_frames,
		output ready);
endinterface

### hw/rtl/bfa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap frame allocator controller
// Sequences each operation and owns the response valid flag.
// ----------------------------------------------------------------------------
module bfa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	input  bfa_pkg::bfa_stat_t stat,
	output bfa_pkg::bfa_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_PICK,
		S_CHECK,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	always_comb begin
		cmd       = '0;
		cmd.load  = (state_q == S_IDLE) && req_valid;
		cmd.exec  = (state_q == S_EXEC);
		cmd.pick  = (state_q == S_PICK);
		cmd.check = (state_q == S_CHECK);
		cmd.emit  = (state_q == S_FINISH) && (!out_valid_q || rsp_ready);
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (stat.exec_last) begin
						state_q <= S_FINISH;
					end else if (stat.op == bfa_pkg::OP_ALLOC) begin
						state_q <= S_PICK;
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_PICK: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (cmd.emit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### hw/rtl/bfa_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap frame allocator datapath
// Used-bit map memory, word summary, free count, address arithmetic and
// response registers.
// ----------------------------------------------------------------------------
module bfa_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [bfa_pkg::ADDR_W-1:0]     cfg_wr_data,
	input  logic [bfa_pkg::OPCODE_W-1:0]   opcode,
	input  logic [bfa_pkg::ADDR_W-1:0]     frame_addr,
	input  bfa_pkg::bfa_cmd_t              cmd,
	output bfa_pkg::bfa_stat_t             stat,
	output logic [bfa_pkg::ADDR_W-1:0]     alloc_addr,
	output logic [bfa_pkg::STATUS_W-1:0]   status,
	output logic [bfa_pkg::FREE_W-1:0]     free_frames
);

	localparam int PAD_W = bfa_pkg::NUM_GROUPS * bfa_pkg::GRP_SIZE;

	logic [bfa_pkg::ADDR_W-1:0]    base_q;
	bfa_pkg::op_t                  op_q;
	logic [bfa_pkg::ADDR_W-1:0]    addr_q;
	logic [bfa_pkg::CNT_W-1:0]     cnt_q;
	logic [bfa_pkg::MAP_WORDS-1:0] valid_q;
	logic [bfa_pkg::MAP_WORDS-1:0] full_q;

	logic [bfa_pkg::WORD_BITS-1:0] mem [bfa_pkg::MAP_WORDS];
	logic [bfa_pkg::WORD_BITS-1:0] rdata_q;
	logic                          rvalid_q;
	logic [bfa_pkg::WIDX_W-1:0]    widx_q;
	logic [bfa_pkg::BIT_W-1:0]     bit_q;

	logic [bfa_pkg::NUM_GROUPS-1:0] grp_hit_s1;
	logic [bfa_pkg::GRP_K_W-1:0]    grp_low_s1 [bfa_pkg::NUM_GROUPS];

	logic [bfa_pkg::ADDR_W-1:0]    res_addr_q;
	bfa_pkg::status_t              res_status_q;
	logic [bfa_pkg::ADDR_W-1:0]    rsp_addr_q;
	bfa_pkg::status_t              rsp_status_q;
	logic [bfa_pkg::FREE_W-1:0]    rsp_free_q;

	logic [bfa_pkg::ADDR_W-1:0]    offset;
	logic                          free_out;
	logic                          free_mis;
	logic [bfa_pkg::WIDX_W-1:0]    free_word;
	logic [bfa_pkg::BIT_W-1:0]     free_bit;
	logic                          cnt_zero;

	logic [PAD_W-1:0]                nonfull_pad;
	logic [bfa_pkg::NUM_GROUPS-1:0]  grp_hit;
	logic [bfa_pkg::GRP_K_W-1:0]     grp_low [bfa_pkg::NUM_GROUPS];
	logic [bfa_pkg::GIDX_W-1:0]      sel_g;
	logic [bfa_pkg::WIDX_W-1:0]      pick_word;

	logic                          rd_en;
	logic [bfa_pkg::WIDX_W-1:0]    rd_addr;
	logic [bfa_pkg::WORD_BITS-1:0] cur_word;
	logic [bfa_pkg::BIT_W-1:0]     zero_bit;
	logic [bfa_pkg::WORD_BITS-1:0] alloc_word;
	logic [bfa_pkg::WORD_BITS-1:0] freed_word;
	logic                          bit_set;
	logic                          wr_en;
	logic [bfa_pkg::WORD_BITS-1:0] wr_data;

	assign offset    = addr_q - base_q;
	assign free_out  = (offset >= bfa_pkg::POOL_BYTES);
	assign free_mis  = (offset[bfa_pkg::FRAME_SHIFT-1:0] != '0);
	assign free_word = offset[bfa_pkg::FRAME_SHIFT + bfa_pkg::BIT_W +: bfa_pkg::WIDX_W];
	assign free_bit  = offset[bfa_pkg::FRAME_SHIFT +: bfa_pkg::BIT_W];
	assign cnt_zero  = (cnt_q == '0);

	always_comb begin
		stat    = '0;
		stat.op = op_q;
		case (op_q)
			bfa_pkg::OP_ALLOC: stat.exec_last = cnt_zero;
			bfa_pkg::OP_FREE:  stat.exec_last = free_out || free_mis;
			default:           stat.exec_last = 1'b1;
		endcase
	end

	// group level of the first non-full word search
	assign nonfull_pad = PAD_W'(~full_q);

	always_comb begin
		for (int g = 0; g < bfa_pkg::NUM_GROUPS; g++) begin
			grp_hit[g] = 1'b0;
			grp_low[g] = '0;
			for (int k = bfa_pkg::GRP_SIZE - 1; k >= 0; k--) begin
				if (nonfull_pad[g * bfa_pkg::GRP_SIZE + k]) begin
					grp_hit[g] = 1'b1;
					grp_low[g] = bfa_pkg::GRP_K_W'(k);
				end
			end
		end
	end

	always_comb begin
		sel_g = '0;
		for (int g = bfa_pkg::NUM_GROUPS - 1; g >= 0; g--) begin
			if (grp_hit_s1[g]) begin
				sel_g = bfa_pkg::GIDX_W'(g);
			end
		end
		pick_word = bfa_pkg::WIDX_W'({sel_g, grp_low_s1[sel_g]});
	end

	assign rd_en   = cmd.pick || (cmd.exec && (op_q == bfa_pkg::OP_FREE) && !stat.exec_last);
	assign rd_addr = cmd.pick ? pick_word : free_word;

	always_comb begin
		cur_word = rvalid_q ? rdata_q : '0;
		if (widx_q == bfa_pkg::WIDX_W'(bfa_pkg::MAP_WORDS - 1)) begin
			cur_word = cur_word | bfa_pkg::TAIL_MASK;
		end
		zero_bit = '0;
		for (int i = bfa_pkg::WORD_BITS - 1; i >= 0; i--) begin
			if (!cur_word[i]) begin
				zero_bit = bfa_pkg::BIT_W'(i);
			end
		end
		alloc_word = cur_word | (bfa_pkg::WORD_BITS'(1) << zero_bit);
		freed_word = cur_word & ~(bfa_pkg::WORD_BITS'(1) << bit_q);
		bit_set    = cur_word[bit_q];
		wr_en      = cmd.check && ((op_q == bfa_pkg::OP_ALLOC) || bit_set);
		wr_data    = (op_q == bfa_pkg::OP_ALLOC) ? alloc_word : freed_word;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[widx_q] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q  <= mem[rd_addr];
			rvalid_q <= valid_q[rd_addr];
			widx_q   <= rd_addr;
		end
		if (cmd.load) begin
			op_q   <= bfa_pkg::op_t'(opcode);
			addr_q <= frame_addr;
		end
		if (cmd.exec) begin
			bit_q      <= free_bit;
			grp_hit_s1 <= grp_hit;
			grp_low_s1 <= grp_low;
			res_addr_q <= '0;
			if (op_q == bfa_pkg::OP_ALLOC && cnt_zero) begin
				res_status_q <= bfa_pkg::ST_FULL;
			end else if (op_q == bfa_pkg::OP_FREE && free_out) begin
				res_status_q <= bfa_pkg::ST_OUT;
			end else if (op_q == bfa_pkg::OP_FREE && free_mis) begin
				res_status_q <= bfa_pkg::ST_MISALIGNED;
			end else begin
				res_status_q <= bfa_pkg::ST_OK;
			end
		end
		if (cmd.check) begin
			if (op_q == bfa_pkg::OP_ALLOC) begin
				res_addr_q <= base_q + (bfa_pkg::ADDR_W'({widx_q, zero_bit})
					<< bfa_pkg::FRAME_SHIFT);
			end else if (!bit_set) begin
				res_status_q <= bfa_pkg::ST_ALREADY_FREE;
			end
		end
		if (cmd.emit) begin
			rsp_addr_q   <= res_addr_q;
			rsp_status_q <= res_status_q;
			rsp_free_q   <= bfa_pkg::FREE_W'(cnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= bfa_pkg::DEFAULT_BASE;
			cnt_q   <= bfa_pkg::CNT_RESET;
			valid_q <= '0;
			full_q  <= '0;
		end else begin
			if (cfg_wr_en) begin
				base_q <= cfg_wr_data;
			end
			if (cmd.exec && op_q == bfa_pkg::OP_CLEAR) begin
				cnt_q   <= bfa_pkg::CNT_RESET;
				valid_q <= '0;
				full_q  <= '0;
			end
			if (wr_en) begin
				valid_q[widx_q] <= 1'b1;
				if (op_q == bfa_pkg::OP_ALLOC) begin
					full_q[widx_q] <= &alloc_word;
					cnt_q          <= cnt_q - bfa_pkg::CNT_W'(1);
				end else begin
					full_q[widx_q] <= 1'b0;
					cnt_q          <= cnt_q + bfa_pkg::CNT_W'(1);
				end
			end
		end
	end

	assign alloc_addr  = rsp_addr_q;
	assign status      = rsp_status_q;
	assign free_frames = rsp_free_q;

endmodule

### hw/rtl/bitmap_frame_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap frame allocator
// First-fit allocator of 4 KiB physical frames from a pool at a set base.
// ----------------------------------------------------------------------------
// One request word gives one response word. A request is taken when the
// controller is idle, also while the previous response still waits. From the
// accepting edge to a loaded response, allocate runs execute with group
// search over the non-full word summary, map read, bit set and response load;
// free runs execute and map read, bit test and response load; clear, no-op
// and rejected requests run execute and response load. Then the controller
// returns to idle before it takes the next request; a stalled response
// holds the controller in its last step. The single-port used-bit map and
// the word summary set these steps. Clear resets all per-word valid flags at
// once, so no clearing pass follows reset.
// The pool base may only be written while no request is in flight.
module bitmap_frame_allocator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [bfa_pkg::ADDR_W-1:0] cfg_wr_data,
	bfa_req_if.sink                    req,
	bfa_rsp_if.source                  rsp
);

	bfa_pkg::bfa_cmd_t  cmd;
	bfa_pkg::bfa_stat_t stat;

	bfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bfa_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.opcode      (req.opcode),
		.frame_addr  (req.frame_addr),
		.cmd         (cmd),
		.stat        (stat),
		.alloc_addr  (rsp.alloc_addr),
		.status      (rsp.status),
		.free_frames (rsp.free_frames)
	);

endmodule

### hw/rtl/bfa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap frame allocator checker
// Port-level properties of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bfa_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [bfa_pkg::ADDR_W-1:0]   alloc_addr,
	input logic [bfa_pkg::STATUS_W-1:0] status,
	input logic [bfa_pkg::FREE_W-1:0]   free_frames
);

	logic [1:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(alloc_addr) && $stable(status)
			&& $stable(free_frames))
		else $error("response word changed while stalled");

	a_rsp_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("response word without a request");

	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> free_frames <= bfa_pkg::FREE_W'(bfa_pkg::NUM_FRAMES))
		else $error("free count above pool size");

	a_addr_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != bfa_pkg::ST_OK |-> alloc_addr == '0)
		else $error("address returned with error status");

	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == bfa_pkg::ST_FULL |-> free_frames == '0)
		else $error("pool full reported with free frames");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.alloc_addr  (rsp.alloc_addr),
	.status      (rsp.status),
	.free_frames (rsp.free_frames)
);
